// ===== rtl/core/mmcn_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcn_pkg
// Shared constants, types and status codes for the min/max normalizer.
// ----------------------------------------------------------------------------
package mmcn_pkg;

  localparam int NUM_CHANNELS = 9;
  localparam int SAMPLE_BITS  = 12;
  localparam int FRAC_BITS    = 8;

  localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  // quotient width: holds 10 << FRAC_BITS
  localparam int QW  = FRAC_BITS + 4;
  // dividend width: (sample span * 10) << FRAC_BITS
  localparam int NW  = SAMPLE_BITS + QW;
  localparam int CW  = $clog2(QW);

  localparam logic [QW-1:0] FULL_SCALE = QW'(10 << FRAC_BITS);

  localparam logic FUNC_CAL  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CLAMP = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_WRITE
  } state_e;

  typedef struct packed {
    logic load;    // latch accepted beat
    logic prep;    // read stores, update range, set up divider
    logic step;    // one quotient bit
    logic finish;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/core/mmcn_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmcn_ctrl
// Sequencer: accept, prepare, divide one bit per cycle, hand off result.
// ----------------------------------------------------------------------------
module mmcn_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mmcn_pkg::sts_t sts_i,
  output mmcn_pkg::cmd_t cmd_o
);
  import mmcn_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = sts_i.need_div ? S_DIV : S_WRITE;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/mmcn_dp.sv =====
// ----------------------------------------------------------------------------
// mmcn_dp
// Range stores, clamp and span setup, restoring divider, output register.
// ----------------------------------------------------------------------------
module mmcn_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mmcn_pkg::cmd_t cmd_i,
  output mmcn_pkg::sts_t sts_o,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           func_i,
  input  logic [3:0]     channel_i,
  input  logic [11:0]    sample_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [11:0]    value_o,
  output logic [1:0]     status_o,
  output logic [11:0]    low_mark_o,
  output logic [11:0]    high_mark_o
);
  import mmcn_pkg::*;

  logic [SAMPLE_BITS-1:0] min_q [NUM_CHANNELS];
  logic [SAMPLE_BITS-1:0] max_q [NUM_CHANNELS];
  logic                   invert_q;

  // latched beat
  logic                   func_q;
  logic [3:0]             chan_q;
  logic [SAMPLE_BITS-1:0] samp_q;

  // divider
  logic [SAMPLE_BITS-1:0] rem_q;
  logic [SAMPLE_BITS-1:0] div_q;
  logic [QW-1:0]          nlow_q;
  logic [QW-1:0]          quo_q;
  logic [CW-1:0]          cnt_q;

  // pending result
  logic                   use_quo_q;
  status_e                res_st_q;
  logic [SAMPLE_BITS-1:0] res_lo_q, res_hi_q;

  logic                   out_valid_q;
  logic [11:0]            value_q, low_q, high_q;
  status_e                status_q;

  // setup logic
  logic [CHW-1:0]         idx;
  logic                   ch_ok;
  logic [SAMPLE_BITS-1:0] lo, hi, cal_lo, cal_hi, s_clamp, span, diff;
  logic                   empty, below, above;
  logic [SAMPLE_BITS+3:0] times10;
  logic [NW-1:0]          num;
  logic                   need_div;

  assign idx     = CHW'(chan_q);
  assign ch_ok   = 32'(chan_q) < NUM_CHANNELS;
  assign lo      = ch_ok ? min_q[idx] : '0;
  assign hi      = ch_ok ? max_q[idx] : '0;
  assign cal_lo  = (samp_q < lo) ? samp_q : lo;
  assign cal_hi  = (samp_q > hi) ? samp_q : hi;
  assign empty   = hi <= lo;
  assign below   = samp_q < lo;
  assign above   = samp_q > hi;
  assign s_clamp = below ? lo : (above ? hi : samp_q);
  assign diff    = s_clamp - lo;
  assign span    = hi - lo;
  assign times10 = {diff, 3'b000} + {2'b00, diff, 1'b0};
  assign num     = {times10, {FRAC_BITS{1'b0}}};
  assign need_div = ch_ok && (func_q == FUNC_READ) && !empty;

  // divider step: quotient is known to fit QW bits, so rem starts below span
  logic [SAMPLE_BITS:0] shifted, trial;
  logic                 fits;
  assign shifted = {rem_q, nlow_q[QW-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign fits    = shifted >= {1'b0, div_q};

  logic [QW-1:0] q_sat, q_fin;
  assign q_sat = (quo_q > FULL_SCALE) ? FULL_SCALE : quo_q;
  assign q_fin = invert_q ? (FULL_SCALE - q_sat) : q_sat;

  assign sts_o.need_div = need_div;
  assign sts_o.div_last = cnt_q == CW'(QW - 1);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        min_q[k] <= '1;
        max_q[k] <= '0;
      end
      invert_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        invert_q <= cfg_wdata_i;
      end
      if (cmd_i.prep && ch_ok && (func_q == FUNC_CAL)) begin
        min_q[idx] <= cal_lo;
        max_q[idx] <= cal_hi;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      chan_q <= channel_i;
      samp_q <= SAMPLE_BITS'(sample_i);
    end
    if (cmd_i.prep) begin
      use_quo_q <= need_div;
      rem_q     <= num[NW-1:QW];
      nlow_q    <= num[QW-1:0];
      div_q     <= span;
      quo_q     <= '0;
      cnt_q     <= '0;
      if (!ch_ok) begin
        res_st_q <= ST_EMPTY;
        res_lo_q <= '0;
        res_hi_q <= '0;
      end else if (func_q == FUNC_CAL) begin
        res_st_q <= ST_OK;
        res_lo_q <= cal_lo;
        res_hi_q <= cal_hi;
      end else begin
        res_lo_q <= lo;
        res_hi_q <= hi;
        if (empty) begin
          res_st_q <= ST_EMPTY;
        end else if (below || above) begin
          res_st_q <= ST_CLAMP;
        end else begin
          res_st_q <= ST_OK;
        end
      end
    end
    if (cmd_i.step) begin
      rem_q  <= fits ? trial[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
      quo_q  <= {quo_q[QW-2:0], fits};
      nlow_q <= {nlow_q[QW-2:0], 1'b0};
      cnt_q  <= cnt_q + 1'b1;
    end
    if (cmd_i.finish) begin
      value_q  <= use_quo_q ? 12'(q_fin) : 12'd0;
      status_q <= res_st_q;
      low_q    <= 12'(res_lo_q);
      high_q   <= 12'(res_hi_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;
  assign low_mark_o  = low_q;
  assign high_mark_o = high_q;

endmodule

// ===== rtl/core/minmax_calibrated_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// minmax_calibrated_normalizer_core
// Per-channel running min/max tracker and 0..10 fixed-point normalizer.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A calibrate beat, or any beat on a channel
// past the last one, or a read of an empty range, goes from prep straight to
// write-back; a read that divides passes between them through the restoring
// divider, which retires one quotient bit per cycle (FRAC_BITS + 4 bits). The
// result sits in an output register, so the next beat is taken while it waits;
// a finished item stalls only if that register is still full.
// Range stores reset directly (minimum all ones, maximum zero); no clearing
// pass is needed. The invert register may be written only while idle.
module minmax_calibrated_normalizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [3:0]  channel_i,
  input  logic [11:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] value_o,
  output logic [1:0]  status_o,
  output logic [11:0] low_mark_o,
  output logic [11:0] high_mark_o
);
  import mmcn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mmcn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mmcn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (func_i),
    .channel_i   (channel_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .low_mark_o  (low_mark_o),
    .high_mark_o (high_mark_o)
  );

`ifndef SYNTHESIS
  // an accepted beat takes the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready right after accept");

  a_empty_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> value_o == 12'd0)
    else $error("empty range result carries a nonzero value");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_CLAMP) ||
                    (status_o == ST_EMPTY))
    else $error("undefined status code");

  // the write-back command never coincides with load, prep or a divider step
  a_no_step_when_out_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !cmd.step && !cmd.prep && !cmd.load)
    else $error("conflicting sequencer commands");
`endif

endmodule
